// File: hdl/char_lcd_nibble_port_sequencer_top_macros.svh
// Assertion macros shared by the sequencer modules.
`ifndef CHAR_LCD_NIBBLE_PORT_SEQUENCER_TOP_MACROS_SVH
`define CHAR_LCD_NIBBLE_PORT_SEQUENCER_TOP_MACROS_SVH

// Same-cycle implication under an active-low reset.
`define CLNPS_ASSERT_IMP(lbl, ck, rn, ante, cons, msg) \
	lbl: assert property (@(posedge ck) disable iff (!(rn)) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication under an active-low reset.
`define CLNPS_ASSERT_NXT(lbl, ck, rn, ante, cons, msg) \
	lbl: assert property (@(posedge ck) disable iff (!(rn)) (ante) |=> (cons)) \
		else $error(msg);

`endif

// File: hdl/clnps_pkg.sv
`default_nettype none

package clnps_pkg;

	localparam logic [2:0] KIND_CHAR    = 3'd0;
	localparam logic [2:0] KIND_CLEAR   = 3'd1;
	localparam logic [2:0] KIND_HOME    = 3'd2;
	localparam logic [2:0] KIND_CURSOR  = 3'd3;
	localparam logic [2:0] KIND_CONTROL = 3'd4;
	localparam logic [2:0] KIND_BL      = 3'd5;
	localparam logic [2:0] KIND_INIT    = 3'd6;

	localparam logic [1:0] REG_ROW_COUNT    = 2'd0;
	localparam logic [1:0] REG_COLUMN_COUNT = 2'd1;
	localparam logic [1:0] REG_BL_ACT_LOW   = 2'd2;
	localparam logic [1:0] REG_BL_AT_INIT   = 2'd3;

	localparam logic [2:0] WAIT_1US  = 3'd0;
	localparam logic [2:0] WAIT_50US = 3'd1;
	localparam logic [2:0] WAIT_1MS  = 3'd2;
	localparam logic [2:0] WAIT_2MS  = 3'd3;
	localparam logic [2:0] WAIT_5MS  = 3'd4;
	localparam logic [2:0] WAIT_50MS = 3'd5;

	localparam logic [1:0] OP_BYTE = 2'd0;
	localparam logic [1:0] OP_ERR  = 2'd1;
	localparam logic [1:0] OP_BL   = 2'd2;
	localparam logic [1:0] OP_INIT = 2'd3;

	localparam logic [7:0] LCD_CLEAR        = 8'h01;
	localparam logic [7:0] LCD_HOME         = 8'h02;
	localparam logic [7:0] CMD_CONTROL      = 8'h08;
	localparam logic [7:0] LCD_FUNCTION_SET = 8'h20;
	localparam logic [7:0] FUNC_2LINE       = 8'h08;
	localparam logic [7:0] LCD_ENTRY_MODE   = 8'h06;
	localparam logic [7:0] CMD_DISP_ON      = 8'h0C;
	localparam logic [3:0] NIB_WAKE         = 4'h3;
	localparam logic [3:0] NIB_FOUR_BIT     = 4'h2;

	localparam logic [4:0] BYTE_LAST_STEP  = 5'd3;
	localparam logic [4:0] INIT_NIB_FIRST  = 5'd1;
	localparam logic [4:0] INIT_BYTE_FIRST = 5'd9;
	localparam logic [4:0] INIT_LAST_STEP  = 5'd28;

	typedef struct packed {
		logic [2:0] row_count;
		logic [5:0] column_count;
		logic       bl_invert;
		logic       bl_on_at_init;
	} cfg_t;

	typedef struct packed {
		logic [1:0] op;
		logic [7:0] data;
		logic       rs;
		logic [2:0] fin_wait;
		logic       bl;
	} job_t;

	function automatic logic [6:0] row_base(input logic [1:0] row);
		logic [6:0] b;
		case (row)
			2'd0: b = 7'h00;
			2'd1: b = 7'h40;
			2'd2: b = 7'h14;
			2'd3: b = 7'h54;
			default: b = 7'h00;
		endcase
		return b;
	endfunction

	// Commands after function set in the power-up sequence.
	function automatic logic [7:0] init_cmd(input logic [2:0] idx);
		logic [7:0] c;
		case (idx)
			3'd1: c = CMD_CONTROL;
			3'd2: c = LCD_CLEAR;
			3'd3: c = LCD_ENTRY_MODE;
			3'd4: c = CMD_DISP_ON;
			default: c = 8'h00;
		endcase
		return c;
	endfunction

	function automatic logic [2:0] init_wait(input logic [2:0] idx);
		logic [2:0] w;
		case (idx)
			3'd0: w = WAIT_1MS;
			3'd1: w = WAIT_1MS;
			3'd2: w = WAIT_2MS;
			3'd3: w = WAIT_1MS;
			3'd4: w = WAIT_50US;
			default: w = WAIT_1US;
		endcase
		return w;
	endfunction

endpackage

`default_nettype wire

// File: hdl/clnps_ifs.sv
`default_nettype none

interface clnps_op_if;
	logic       valid;
	logic       ready;
	logic [2:0] kind;
	logic [7:0] char_code;
	logic [5:0] cursor_col;
	logic [1:0] cursor_row;
	logic       display_on;
	logic       cursor_on;
	logic       blink_on;
	logic       backlight_on;

	modport source (
		output valid, kind, char_code, cursor_col, cursor_row,
		output display_on, cursor_on, blink_on, backlight_on,
		input  ready
	);
	modport sink (
		input  valid, kind, char_code, cursor_col, cursor_row,
		input  display_on, cursor_on, blink_on, backlight_on,
		output ready
	);
endinterface

interface clnps_res_if;
	logic       valid;
	logic       ready;
	logic [7:0] port_byte;
	logic [2:0] wait_class;
	logic       status;
	logic       last;

	modport source (
		output valid, port_byte, wait_class, status, last,
		input  ready
	);
	modport sink (
		input  valid, port_byte, wait_class, status, last,
		output ready
	);
endinterface

`default_nettype wire

// File: hdl/clnps_front.sv
`default_nettype none

module clnps_front (
	clnps_op_if.sink          op,
	input  var clnps_pkg::cfg_t cfg,
	input  wire logic         full,
	output logic              push,
	output clnps_pkg::job_t   job
);

	logic       out_of_range;
	logic [6:0] addr;

	assign op.ready = !full;

	assign out_of_range = ({1'b0, op.cursor_row} >= cfg.row_count)
		|| (op.cursor_col >= cfg.column_count);
	assign addr = clnps_pkg::row_base(op.cursor_row) + {1'b0, op.cursor_col};

	always_comb begin
		job.op       = clnps_pkg::OP_BYTE;
		job.data     = 8'h00;
		job.rs       = 1'b0;
		job.fin_wait = clnps_pkg::WAIT_50US;
		job.bl       = op.backlight_on;
		push         = op.valid && !full;
		case (op.kind)
			clnps_pkg::KIND_CHAR: begin
				job.data = op.char_code;
				job.rs   = 1'b1;
			end
			clnps_pkg::KIND_CLEAR: begin
				job.data     = clnps_pkg::LCD_CLEAR;
				job.fin_wait = clnps_pkg::WAIT_2MS;
			end
			clnps_pkg::KIND_HOME: begin
				job.data     = clnps_pkg::LCD_HOME;
				job.fin_wait = clnps_pkg::WAIT_2MS;
			end
			clnps_pkg::KIND_CURSOR: begin
				if (out_of_range) begin
					job.op = clnps_pkg::OP_ERR;
				end
				job.data = {1'b1, addr};
			end
			clnps_pkg::KIND_CONTROL: begin
				job.data = clnps_pkg::CMD_CONTROL
					| {5'b00000, op.display_on, op.cursor_on, op.blink_on};
			end
			clnps_pkg::KIND_BL: begin
				job.op = clnps_pkg::OP_BL;
			end
			clnps_pkg::KIND_INIT: begin
				job.op   = clnps_pkg::OP_INIT;
				job.data = clnps_pkg::LCD_FUNCTION_SET
					| ((cfg.row_count > 3'd1) ? clnps_pkg::FUNC_2LINE : 8'h00);
				job.bl   = cfg.bl_on_at_init;
			end
			default: begin
				// An unused kind is taken and dropped.
				push = 1'b0;
			end
		endcase
	end

endmodule

`default_nettype wire

// File: hdl/clnps_queue.sv
`default_nettype none

module clnps_queue #(
	parameter int DEPTH = 2
) (
	input  wire logic           clk,
	input  wire logic           arst_n,
	input  wire logic           push,
	input  var clnps_pkg::job_t push_job,
	input  wire logic           pop,
	output logic                full,
	output logic                head_valid,
	output clnps_pkg::job_t     head_job
);

	`include "char_lcd_nibble_port_sequencer_top_macros.svh"

	localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CW = $clog2(DEPTH + 1);

	clnps_pkg::job_t mem_q [DEPTH];
	logic [PW-1:0]   wr_ptr_q;
	logic [PW-1:0]   rd_ptr_q;
	logic [CW-1:0]   count_q;

	function automatic logic [PW-1:0] next_ptr(input logic [PW-1:0] p);
		return (p == PW'(DEPTH - 1)) ? '0 : p + 1'b1;
	endfunction

	assign full       = (count_q == CW'(DEPTH));
	assign head_valid = (count_q != '0);
	assign head_job   = mem_q[rd_ptr_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= next_ptr(wr_ptr_q);
			end
			if (pop) begin
				rd_ptr_q <= next_ptr(rd_ptr_q);
			end
			if (push && !pop) begin
				count_q <= count_q + 1'b1;
			end else if (pop && !push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= push_job;
		end
	end

	`CLNPS_ASSERT_IMP(a_no_push_full, clk, arst_n, push, !full, "push into a full queue")
	`CLNPS_ASSERT_IMP(a_no_pop_empty, clk, arst_n, pop, head_valid, "pop from an empty queue")
	`CLNPS_ASSERT_NXT(a_count_down, clk, arst_n, pop && !push,
		count_q == $past(count_q) - 1'b1, "queue fill count did not fall on pop")

endmodule

`default_nettype wire

// File: hdl/clnps_back.sv
`default_nettype none

module clnps_back (
	input  wire logic           clk,
	input  wire logic           arst_n,
	input  var clnps_pkg::cfg_t cfg,
	input  wire logic           job_valid,
	input  var clnps_pkg::job_t job,
	output logic                pop,
	clnps_res_if.source         res
);

	`include "char_lcd_nibble_port_sequencer_top_macros.svh"

	logic [4:0] step_q;
	logic       backlight_bit_q;
	logic       res_valid_q;
	logic [7:0] port_byte_q;
	logic [2:0] wait_q;
	logic       status_q;
	logic       last_q;

	logic       load;
	logic       new_bl;
	logic       bl_upd;
	logic       bl_now;
	logic       cur_last;
	logic       cur_status;
	logic       is_nibble;
	logic       plain_byte;
	logic [3:0] nib;
	logic       e_bit;
	logic [2:0] cur_wait;
	logic [7:0] cur_port;
	logic [4:0] nib_k;
	logic [4:0] byte_k;
	logic [7:0] seq_data;
	logic [1:0] seq_sub;
	logic [2:0] seq_fin;

	assign load   = job_valid && (!res_valid_q || res.ready);
	assign new_bl = job.bl ^ cfg.bl_invert;
	assign nib_k  = step_q - clnps_pkg::INIT_NIB_FIRST;
	assign byte_k = step_q - clnps_pkg::INIT_BYTE_FIRST;

	always_comb begin
		bl_upd     = 1'b0;
		cur_last   = 1'b0;
		cur_status = 1'b0;
		is_nibble  = 1'b0;
		plain_byte = 1'b0;
		nib        = 4'h0;
		e_bit      = 1'b0;
		cur_wait   = clnps_pkg::WAIT_1US;
		seq_data   = job.data;
		seq_sub    = step_q[1:0];
		seq_fin    = job.fin_wait;
		case (job.op)
			clnps_pkg::OP_BYTE: begin
				is_nibble = 1'b1;
				cur_last  = (step_q == clnps_pkg::BYTE_LAST_STEP);
			end
			clnps_pkg::OP_ERR: begin
				cur_status = 1'b1;
				cur_last   = 1'b1;
			end
			clnps_pkg::OP_BL: begin
				plain_byte = 1'b1;
				bl_upd     = 1'b1;
				cur_last   = 1'b1;
			end
			clnps_pkg::OP_INIT: begin
				if (step_q == 5'd0) begin
					plain_byte = 1'b1;
					bl_upd     = 1'b1;
					cur_wait   = clnps_pkg::WAIT_50MS;
				end else if (step_q < clnps_pkg::INIT_BYTE_FIRST) begin
					// Wake-up nibbles: three of 3h, then 2h to enter 4-bit mode.
					nib   = (nib_k[2:1] == 2'd3) ? clnps_pkg::NIB_FOUR_BIT
						: clnps_pkg::NIB_WAKE;
					e_bit = !nib_k[0];
					if (nib_k[0]) begin
						cur_wait = nib_k[2] ? clnps_pkg::WAIT_1MS : clnps_pkg::WAIT_5MS;
					end
				end else begin
					is_nibble = 1'b1;
					seq_sub   = byte_k[1:0];
					seq_fin   = clnps_pkg::init_wait(byte_k[4:2]);
					if (byte_k[4:2] != 3'd0) begin
						seq_data = clnps_pkg::init_cmd(byte_k[4:2]);
					end
					cur_last = (step_q == clnps_pkg::INIT_LAST_STEP);
				end
			end
			default: begin
				cur_last = 1'b1;
			end
		endcase
		if (is_nibble) begin
			nib   = seq_sub[1] ? seq_data[3:0] : seq_data[7:4];
			e_bit = !seq_sub[0];
			if (seq_sub[0]) begin
				cur_wait = seq_sub[1] ? seq_fin : clnps_pkg::WAIT_50US;
			end
		end
	end

	assign bl_now   = bl_upd ? new_bl : backlight_bit_q;
	assign cur_port = cur_status ? 8'h00
		: plain_byte ? {4'h0, bl_now, 3'b000}
		: {nib, bl_now, e_bit, 1'b0, job.rs && (job.op == clnps_pkg::OP_BYTE)};
	assign pop = load && cur_last;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			step_q          <= '0;
			backlight_bit_q <= 1'b0;
			res_valid_q     <= 1'b0;
		end else begin
			if (load) begin
				step_q <= cur_last ? 5'd0 : step_q + 1'b1;
				if (bl_upd) begin
					backlight_bit_q <= new_bl;
				end
				res_valid_q <= 1'b1;
			end else if (res.ready) begin
				res_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			port_byte_q <= cur_port;
			wait_q      <= cur_status ? clnps_pkg::WAIT_1US : cur_wait;
			status_q    <= cur_status;
			last_q      <= cur_last;
		end
	end

	assign res.valid      = res_valid_q;
	assign res.port_byte  = port_byte_q;
	assign res.wait_class = wait_q;
	assign res.status     = status_q;
	assign res.last       = last_q;

	`CLNPS_ASSERT_IMP(a_byte_steps, clk, arst_n, job_valid && (job.op == clnps_pkg::OP_BYTE),
		step_q <= clnps_pkg::BYTE_LAST_STEP, "byte sequence ran past four transfers")
	`CLNPS_ASSERT_IMP(a_init_steps, clk, arst_n, job_valid && (job.op == clnps_pkg::OP_INIT),
		step_q <= clnps_pkg::INIT_LAST_STEP, "power-up sequence ran past its end")
	`CLNPS_ASSERT_IMP(a_bl_change, clk, arst_n, !$stable(backlight_bit_q),
		$past(load && bl_upd), "backlight bit changed outside a backlight transfer")
	`CLNPS_ASSERT_IMP(a_err_shape, clk, arst_n, res_valid_q && status_q,
		last_q && (port_byte_q == 8'h00), "error result is not a lone empty transfer")

endmodule

`default_nettype wire

// File: hdl/char_lcd_nibble_port_sequencer_top.sv
// Channel  Dir  Payload                                                Transfer when
// op       in   kind, char_code, cursor_col, cursor_row, flags         op.valid && op.ready
// res      out  port_byte, wait_class, status, last                    res.valid && res.ready
// cfg      in   cfg_index selects the register, cfg_wdata the value    cfg_we
//
// One port byte leaves per cycle while res is not stalled: a character or command takes four
// port bytes, a backlight change or a cursor error one, and the power-up sequence 29.
// The operation queue of QUEUE_DEPTH entries lets new operations be taken while the
// sequencer and the output register are still busy; op.ready falls only when it is full.
// A stall on res holds the output register and the sequencer step.
// Reset clears the queue, the sequencer step and the backlight bit, and loads the
// register defaults; the block is ready as soon as reset is released.
`default_nettype none

module char_lcd_nibble_port_sequencer_top #(
	parameter int QUEUE_DEPTH = 2
) (
	input  wire logic   clk,
	input  wire logic   arst_n,
	input  wire logic   cfg_we,
	input  wire logic [1:0] cfg_index,
	input  wire logic [5:0] cfg_wdata,
	clnps_op_if.sink    op,
	clnps_res_if.source res
);

	clnps_pkg::cfg_t cfg_q;
	clnps_pkg::job_t push_job;
	clnps_pkg::job_t head_job;
	logic            push;
	logic            pop;
	logic            full;
	logic            head_valid;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.row_count     <= 3'd2;
			cfg_q.column_count  <= 6'd16;
			cfg_q.bl_invert     <= 1'b0;
			cfg_q.bl_on_at_init <= 1'b1;
		end else if (cfg_we) begin
			case (cfg_index)
				clnps_pkg::REG_ROW_COUNT:    cfg_q.row_count     <= cfg_wdata[2:0];
				clnps_pkg::REG_COLUMN_COUNT: cfg_q.column_count  <= cfg_wdata;
				clnps_pkg::REG_BL_ACT_LOW:   cfg_q.bl_invert     <= cfg_wdata[0];
				clnps_pkg::REG_BL_AT_INIT:   cfg_q.bl_on_at_init <= cfg_wdata[0];
				default: begin
				end
			endcase
		end
	end

	clnps_front u_front (
		.op   (op),
		.cfg  (cfg_q),
		.full (full),
		.push (push),
		.job  (push_job)
	);

	clnps_queue #(
		.DEPTH (QUEUE_DEPTH)
	) u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push       (push),
		.push_job   (push_job),
		.pop        (pop),
		.full       (full),
		.head_valid (head_valid),
		.head_job   (head_job)
	);

	clnps_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg       (cfg_q),
		.job_valid (head_valid),
		.job       (head_job),
		.pop       (pop),
		.res       (res)
	);

endmodule

`default_nettype wire

// File: tb/tb_top.sv
`timescale 1ns / 100ps

module tb_top;

	localparam int HALF_PERIOD = 10;
	localparam int RESET_CYCLES = 7;
	localparam int SETTLE_CYCLES = 16;
	localparam int CYCLE_LIMIT = 200000;
	localparam int IDLE_PERCENT = 15;
	localparam int MAX_REPORTS = 10;
	localparam logic [2:0] KIND_UNUSED = 3'd7;
	localparam logic [7:0] CMD_SET_DDRAM = 8'h80;

	typedef struct {
		logic [2:0] kind;
		logic [7:0] char_code;
		logic [5:0] col;
		logic [1:0] row;
		logic       disp;
		logic       curs;
		logic       blink;
		logic       bl;
	} lcd_op_t;

	typedef struct {
		logic [7:0] port_byte;
		logic [2:0] wait_class;
		logic       status;
		logic       last;
	} lcd_result_t;

	logic       clk = 1'b0;
	logic       arst_n;
	logic       cfg_we;
	logic [1:0] cfg_index;
	logic [5:0] cfg_wdata;

	clnps_op_if  op_ch ();
	clnps_res_if res_ch ();

	char_lcd_nibble_port_sequencer_top DUT (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_wdata (cfg_wdata),
		.op        (op_ch),
		.res       (res_ch)
	);

	// Local copy of the panel settings and the physical backlight bit.
	logic [2:0] rows_cfg;
	logic [5:0] cols_cfg;
	logic       bl_act_low_cfg;
	logic       bl_init_cfg;
	logic       bl_phys;

	logic [6:0] row_start [4] = '{7'h00, 7'h40, 7'h14, 7'h54};

	lcd_result_t port_bytes_due [$];
	int          mismatches = 0;
	int          cycle_count = 0;
	bit          steady = 1'b0;

	always #HALF_PERIOD clk = ~clk;

	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count == CYCLE_LIMIT) begin
			$display("** char_lcd_nibble_port_sequencer_top: FAILED **");
			$finish;
		end
	end

	function automatic bit take_a_break();
		return !steady && ($urandom_range(99) < IDLE_PERCENT);
	endfunction

	function automatic void queue_byte(input logic [7:0] pb, input logic [2:0] wc,
			input logic st);
		lcd_result_t r;
		r.port_byte = pb;
		r.wait_class = wc;
		r.status = st;
		r.last = 1'b0;
		port_bytes_due.push_back(r);
	endfunction

	function automatic void queue_nibble(input logic [3:0] nib, input logic rs,
			input logic [2:0] wc);
		logic [7:0] base;
		base = {nib, bl_phys, 1'b0, 1'b0, rs};
		queue_byte(base | 8'h04, clnps_pkg::WAIT_1US, 1'b0);
		queue_byte(base, wc, 1'b0);
	endfunction

	function automatic void queue_lcd_byte(input logic [7:0] b, input logic rs,
			input logic [2:0] wc);
		queue_nibble(b[7:4], rs, clnps_pkg::WAIT_50US);
		queue_nibble(b[3:0], rs, wc);
	endfunction

	function automatic void apply_backlight(input logic logical, input logic [2:0] wc);
		bl_phys = logical ^ bl_act_low_cfg;
		queue_byte({4'h0, bl_phys, 3'b000}, wc, 1'b0);
	endfunction

	function automatic void predict_port_bytes(input lcd_op_t item);
		int          start;
		logic [7:0]  addr;
		lcd_result_t tail;
		start = port_bytes_due.size();
		case (item.kind)
			clnps_pkg::KIND_CHAR: begin
				queue_lcd_byte(item.char_code, 1'b1, clnps_pkg::WAIT_50US);
			end
			clnps_pkg::KIND_CLEAR: begin
				queue_lcd_byte(clnps_pkg::LCD_CLEAR, 1'b0, clnps_pkg::WAIT_2MS);
			end
			clnps_pkg::KIND_HOME: begin
				queue_lcd_byte(clnps_pkg::LCD_HOME, 1'b0, clnps_pkg::WAIT_2MS);
			end
			clnps_pkg::KIND_CURSOR: begin
				if ({1'b0, item.row} >= rows_cfg || item.col >= cols_cfg) begin
					queue_byte(8'h00, clnps_pkg::WAIT_1US, 1'b1);
				end else begin
					addr = {1'b0, row_start[item.row]} + {2'b00, item.col};
					queue_lcd_byte(CMD_SET_DDRAM | {1'b0, addr[6:0]}, 1'b0,
						clnps_pkg::WAIT_50US);
				end
			end
			clnps_pkg::KIND_CONTROL: begin
				queue_lcd_byte(clnps_pkg::CMD_CONTROL
					| {5'b0, item.disp, item.curs, item.blink},
					1'b0, clnps_pkg::WAIT_50US);
			end
			clnps_pkg::KIND_BL: apply_backlight(item.bl, clnps_pkg::WAIT_1US);
			clnps_pkg::KIND_INIT: begin
				apply_backlight(bl_init_cfg, clnps_pkg::WAIT_50MS);
				queue_nibble(clnps_pkg::NIB_WAKE, 1'b0, clnps_pkg::WAIT_5MS);
				queue_nibble(clnps_pkg::NIB_WAKE, 1'b0, clnps_pkg::WAIT_5MS);
				queue_nibble(clnps_pkg::NIB_WAKE, 1'b0, clnps_pkg::WAIT_1MS);
				queue_nibble(clnps_pkg::NIB_FOUR_BIT, 1'b0, clnps_pkg::WAIT_1MS);
				queue_lcd_byte(clnps_pkg::LCD_FUNCTION_SET
					| (rows_cfg > 3'd1 ? clnps_pkg::FUNC_2LINE : 8'h00), 1'b0,
					clnps_pkg::WAIT_1MS);
				queue_lcd_byte(clnps_pkg::CMD_CONTROL, 1'b0, clnps_pkg::WAIT_1MS);
				queue_lcd_byte(clnps_pkg::LCD_CLEAR, 1'b0, clnps_pkg::WAIT_2MS);
				queue_lcd_byte(clnps_pkg::LCD_ENTRY_MODE, 1'b0, clnps_pkg::WAIT_1MS);
				queue_lcd_byte(clnps_pkg::CMD_DISP_ON, 1'b0, clnps_pkg::WAIT_50US);
			end
			default: ;
		endcase
		if (port_bytes_due.size() > start) begin
			tail = port_bytes_due.pop_back();
			tail.last = 1'b1;
			port_bytes_due.push_back(tail);
		end
	endfunction

	function automatic lcd_op_t mk_op(input logic [2:0] kind, input logic [7:0] ch,
			input logic [5:0] col, input logic [1:0] row, input logic disp,
			input logic curs, input logic blink, input logic bl);
		lcd_op_t item;
		item.kind = kind;
		item.char_code = ch;
		item.col = col;
		item.row = row;
		item.disp = disp;
		item.curs = curs;
		item.blink = blink;
		item.bl = bl;
		return item;
	endfunction

	function automatic lcd_op_t random_op();
		lcd_op_t item;
		int      r;
		int      rows_lim;
		item = mk_op(clnps_pkg::KIND_CHAR, 8'($urandom_range(255)), 6'($urandom_range(63)),
			2'($urandom_range(3)), 1'($urandom_range(1)), 1'($urandom_range(1)),
			1'($urandom_range(1)), 1'($urandom_range(1)));
		r = $urandom_range(99);
		if (r < 30) item.kind = clnps_pkg::KIND_CHAR;
		else if (r < 38) item.kind = clnps_pkg::KIND_CLEAR;
		else if (r < 46) item.kind = clnps_pkg::KIND_HOME;
		else if (r < 66) item.kind = clnps_pkg::KIND_CURSOR;
		else if (r < 80) item.kind = clnps_pkg::KIND_CONTROL;
		else if (r < 90) item.kind = clnps_pkg::KIND_BL;
		else if (r < 96) item.kind = clnps_pkg::KIND_INIT;
		else item.kind = KIND_UNUSED;
		// Most cursor moves land on the panel; the rest probe the range check.
		rows_lim = (rows_cfg > 3'd4) ? 4 : int'(rows_cfg);
		if (item.kind == clnps_pkg::KIND_CURSOR && rows_lim > 0 && cols_cfg != 6'd0
				&& $urandom_range(99) < 70) begin
			item.row = 2'($urandom_range(rows_lim - 1));
			item.col = 6'($urandom_range(int'(cols_cfg) - 1));
		end
		return item;
	endfunction

	task automatic send_op(input lcd_op_t item);
		while (take_a_break()) begin
			op_ch.valid <= 1'b0;
			@(posedge clk);
		end
		op_ch.valid <= 1'b1;
		op_ch.kind <= item.kind;
		op_ch.char_code <= item.char_code;
		op_ch.cursor_col <= item.col;
		op_ch.cursor_row <= item.row;
		op_ch.display_on <= item.disp;
		op_ch.cursor_on <= item.curs;
		op_ch.blink_on <= item.blink;
		op_ch.backlight_on <= item.bl;
		do @(posedge clk); while (!op_ch.ready);
		predict_port_bytes(item);
	endtask

	task automatic settle();
		op_ch.valid <= 1'b0;
		while (port_bytes_due.size() != 0) @(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic write_reg(input logic [1:0] idx, input logic [5:0] val);
		settle();
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_wdata <= val;
		@(posedge clk);
		cfg_we <= 1'b0;
		case (idx)
			clnps_pkg::REG_ROW_COUNT: rows_cfg = val[2:0];
			clnps_pkg::REG_COLUMN_COUNT: cols_cfg = val;
			clnps_pkg::REG_BL_ACT_LOW: bl_act_low_cfg = val[0];
			clnps_pkg::REG_BL_AT_INIT: bl_init_cfg = val[0];
			default: ;
		endcase
	endtask

	task automatic set_panel(input logic [2:0] rows, input logic [5:0] cols,
			input logic act_low, input logic at_init);
		write_reg(clnps_pkg::REG_ROW_COUNT, {3'b000, rows});
		write_reg(clnps_pkg::REG_COLUMN_COUNT, cols);
		write_reg(clnps_pkg::REG_BL_ACT_LOW, {5'b0, act_low});
		write_reg(clnps_pkg::REG_BL_AT_INIT, {5'b0, at_init});
	endtask

	task automatic report_mismatch(input string what, input lcd_result_t exp,
			input lcd_result_t got);
		mismatches++;
		if (mismatches <= MAX_REPORTS) begin
			$display("%0t: %s: expected byte %h wait %0d status %0d last %0d",
				$realtime, what, exp.port_byte, exp.wait_class, exp.status, exp.last);
			$display("    got byte %h wait %0d status %0d last %0d",
				got.port_byte, got.wait_class, got.status, got.last);
		end
	endtask

	// Each port byte transfer is compared with the oldest outstanding prediction.
	always @(posedge clk) begin
		lcd_result_t got;
		lcd_result_t exp;
		if (arst_n) begin
			if (res_ch.valid && res_ch.ready) begin
				got.port_byte = res_ch.port_byte;
				got.wait_class = res_ch.wait_class;
				got.status = res_ch.status;
				got.last = res_ch.last;
				if (port_bytes_due.size() == 0) begin
					exp = '{8'h00, 3'd0, 1'b0, 1'b0};
					report_mismatch("transfer with nothing outstanding", exp, got);
				end else begin
					exp = port_bytes_due.pop_front();
					if (got.port_byte !== exp.port_byte || got.wait_class !== exp.wait_class
							|| got.status !== exp.status || got.last !== exp.last) begin
						report_mismatch("port byte mismatch", exp, got);
					end
				end
			end
			res_ch.ready <= !take_a_break();
		end else begin
			res_ch.ready <= 1'b0;
		end
	end

	task automatic test_directed_ops();
		send_op(mk_op(clnps_pkg::KIND_INIT, 8'h00, 6'd0, 2'd0, 1'b0, 1'b0, 1'b0, 1'b0));
		send_op(mk_op(clnps_pkg::KIND_CHAR, 8'h00, 6'd0, 2'd0, 1'b0, 1'b0, 1'b0, 1'b0));
		send_op(mk_op(clnps_pkg::KIND_CHAR, 8'hFF, 6'd63, 2'd3, 1'b1, 1'b1, 1'b1, 1'b1));
		send_op(mk_op(clnps_pkg::KIND_CLEAR, 8'h00, 6'd0, 2'd0, 1'b0, 1'b0, 1'b0, 1'b0));
		send_op(mk_op(clnps_pkg::KIND_HOME, 8'h00, 6'd0, 2'd0, 1'b0, 1'b0, 1'b0, 1'b0));
		send_op(mk_op(clnps_pkg::KIND_CURSOR, 8'h00, 6'd0, 2'd0, 1'b0, 1'b0, 1'b0, 1'b0));
		send_op(mk_op(clnps_pkg::KIND_CURSOR, 8'h00, 6'd15, 2'd1, 1'b0, 1'b0, 1'b0, 1'b0));
		send_op(mk_op(clnps_pkg::KIND_CURSOR, 8'h00, 6'd0, 2'd2, 1'b0, 1'b0, 1'b0, 1'b0));
		send_op(mk_op(clnps_pkg::KIND_CURSOR, 8'h00, 6'd16, 2'd0, 1'b0, 1'b0, 1'b0, 1'b0));
		send_op(mk_op(clnps_pkg::KIND_CONTROL, 8'h00, 6'd0, 2'd0, 1'b1, 1'b1, 1'b1, 1'b0));
		send_op(mk_op(clnps_pkg::KIND_CONTROL, 8'h00, 6'd0, 2'd0, 1'b0, 1'b0, 1'b0, 1'b0));
		send_op(mk_op(clnps_pkg::KIND_BL, 8'h00, 6'd0, 2'd0, 1'b0, 1'b0, 1'b0, 1'b1));
		send_op(mk_op(clnps_pkg::KIND_BL, 8'h00, 6'd0, 2'd0, 1'b0, 1'b0, 1'b0, 1'b0));
		send_op(mk_op(KIND_UNUSED, 8'hFF, 6'd63, 2'd3, 1'b1, 1'b1, 1'b1, 1'b1));
		send_op(mk_op(clnps_pkg::KIND_CHAR, 8'h5A, 6'd0, 2'd0, 1'b0, 1'b0, 1'b0, 1'b0));
		settle();
	endtask

	task automatic test_register_settings();
		// Four-row map with the widest column bound, so the address wraps past 7 bits.
		set_panel(3'd4, 6'd63, 1'b1, 1'b0);
		send_op(mk_op(clnps_pkg::KIND_CURSOR, 8'h00, 6'd62, 2'd3, 1'b0, 1'b0, 1'b0, 1'b0));
		send_op(mk_op(clnps_pkg::KIND_CURSOR, 8'h00, 6'd39, 2'd2, 1'b0, 1'b0, 1'b0, 1'b0));
		send_op(mk_op(clnps_pkg::KIND_BL, 8'h00, 6'd0, 2'd0, 1'b0, 1'b0, 1'b0, 1'b1));
		send_op(mk_op(clnps_pkg::KIND_INIT, 8'h00, 6'd0, 2'd0, 1'b0, 1'b0, 1'b0, 1'b0));
		write_reg(clnps_pkg::REG_ROW_COUNT, 6'd1);
		write_reg(clnps_pkg::REG_COLUMN_COUNT, 6'd1);
		send_op(mk_op(clnps_pkg::KIND_INIT, 8'h00, 6'd0, 2'd0, 1'b0, 1'b0, 1'b0, 1'b0));
		send_op(mk_op(clnps_pkg::KIND_CURSOR, 8'h00, 6'd0, 2'd0, 1'b0, 1'b0, 1'b0, 1'b0));
		send_op(mk_op(clnps_pkg::KIND_CURSOR, 8'h00, 6'd0, 2'd1, 1'b0, 1'b0, 1'b0, 1'b0));
		set_panel(3'd0, 6'd0, 1'b0, 1'b1);
		send_op(mk_op(clnps_pkg::KIND_CURSOR, 8'h00, 6'd0, 2'd0, 1'b0, 1'b0, 1'b0, 1'b0));
		write_reg(clnps_pkg::REG_ROW_COUNT, 6'd7);
		write_reg(clnps_pkg::REG_COLUMN_COUNT, 6'd40);
		send_op(mk_op(clnps_pkg::KIND_CURSOR, 8'h00, 6'd39, 2'd3, 1'b0, 1'b0, 1'b0, 1'b0));
		send_op(mk_op(clnps_pkg::KIND_CURSOR, 8'h00, 6'd40, 2'd0, 1'b0, 1'b0, 1'b0, 1'b0));
		settle();
	endtask

	task automatic test_random_traffic();
		for (int phase = 0; phase < 4; phase++) begin
			case (phase)
				0: set_panel(3'd4, 6'd40, 1'b0, 1'b1);
				1: set_panel(3'd1, 6'd1, 1'b1, 1'b0);
				default: begin
					set_panel(3'($urandom_range(7)), 6'($urandom_range(63)),
						1'($urandom_range(1)), 1'($urandom_range(1)));
				end
			endcase
			repeat (39) send_op(random_op());
		end
		settle();
	endtask

	task automatic test_back_to_back();
		set_panel(3'd2, 6'd16, 1'b0, 1'b1);
		steady = 1'b1;
		repeat (30) send_op(random_op());
		settle();
		steady = 1'b0;
	endtask

	initial begin
		arst_n = 1'b0;
		cfg_we = 1'b0;
		cfg_index = '0;
		cfg_wdata = '0;
		op_ch.valid = 1'b0;
		op_ch.kind = '0;
		op_ch.char_code = '0;
		op_ch.cursor_col = '0;
		op_ch.cursor_row = '0;
		op_ch.display_on = 1'b0;
		op_ch.cursor_on = 1'b0;
		op_ch.blink_on = 1'b0;
		op_ch.backlight_on = 1'b0;
		rows_cfg = 3'd2;
		cols_cfg = 6'd16;
		bl_act_low_cfg = 1'b0;
		bl_init_cfg = 1'b1;
		bl_phys = 1'b0;
		repeat (RESET_CYCLES) @(posedge clk);
		arst_n <= 1'b1;
		test_directed_ops();
		test_register_settings();
		test_random_traffic();
		test_back_to_back();
		settle();
		if (mismatches == 0) begin
			$display("** char_lcd_nibble_port_sequencer_top: PASSED **");
		end else begin
			$display("** char_lcd_nibble_port_sequencer_top: FAILED **");
		end
		$finish;
	end

endmodule

// File: files.f
+incdir+hdl
hdl/clnps_pkg.sv
hdl/clnps_ifs.sv
hdl/clnps_front.sv
hdl/clnps_queue.sv
hdl/clnps_back.sv
hdl/char_lcd_nibble_port_sequencer_top.sv
tb/tb_top.sv
